// ===== rtl/pn2d_pkg.sv =====
// Package for the 2D gradient noise sampler: field widths, operation codes
// and shared types. No dependencies.
package pn2d_pkg;
   localparam int TABLE_SIZE_DEF = 256;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int COORD_W        = 32;
   localparam int IDX_W          = 8;
   localparam int VAL_W          = 8;
   localparam int NOISE_W        = 17;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_LOAD   = 1'b1
   } op_type;
endpackage

// ===== rtl/pn2d_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pn2d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/pn2d_fifo.sv =====
// Short queue between the front and back of the sampler and at
// its output. Depends on nothing but its parameters.
module pn2d_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int AW = $clog2(DEPTH);
   logic [WIDTH-1:0] q_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   assign full     = cnt_ff == (AW+1)'(DEPTH);
   assign empty    = cnt_ff == '0;
   assign pop_data = q_ff[rp_ff];
   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= push_data;
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (pop)  rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end
endmodule

// ===== rtl/pn2d_front.sv =====
// Front part: accepts items, writes table loads, splits sample coordinates,
// and runs the six table lookups through RAM copies. Uses pn2d_pkg, pn2d_ram.
module pn2d_front #(
   parameter int FRAC_BITS  = pn2d_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_operation,
   input  logic [pn2d_pkg::IDX_W-1:0]  req_table_index,
   input  logic [pn2d_pkg::VAL_W-1:0]  req_table_value,
   input  logic [FRAC_BITS-1:0]        fx_in,
   input  logic [FRAC_BITS-1:0]        fy_in,
   input  logic [pn2d_pkg::COORD_W-1:0] x_in,
   input  logic [pn2d_pkg::COORD_W-1:0] y_in,
   input  logic                        advance,
   output logic                        out_valid,
   output logic [1:0]                  out_aa,
   output logic [1:0]                  out_ab,
   output logic [1:0]                  out_ba,
   output logic [1:0]                  out_bb,
   output logic [FRAC_BITS-1:0]        out_fx,
   output logic [FRAC_BITS-1:0]        out_fy
);
   localparam int TABLE_SIZE = pn2d_pkg::TABLE_SIZE_DEF;
   localparam int AW = $clog2(TABLE_SIZE);
   localparam int VW = pn2d_pkg::VAL_W;

   logic acc, is_load, wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] cx, cy;
   logic [VW-1:0] pa, pb, aa, ab, ba, bb;

   assign req_stall = !advance;
   assign acc     = req_valid && advance;
   assign is_load = req_operation == pn2d_pkg::OP_LOAD;
   assign wr_en   = acc && is_load;
   assign wr_addr = AW'(req_table_index);
   assign cx      = x_in[FRAC_BITS +: AW];
   assign cy      = y_in[FRAC_BITS +: AW];

   // stage 1
   logic          v1_ff;
   logic [AW-1:0] cy1_ff;
   logic [FRAC_BITS-1:0] fx1_ff, fy1_ff;
   // stage 2
   logic          v2_ff;
   logic [FRAC_BITS-1:0] fx2_ff, fy2_ff;

   pn2d_ram #(.WIDTH(VW), .DEPTH(TABLE_SIZE)) u_pa (.clock, .wr_en, .wr_addr,
      .wr_data(req_table_value), .rd_en(advance), .rd_addr(cx), .rd_data(pa));
   pn2d_ram #(.WIDTH(VW), .DEPTH(TABLE_SIZE)) u_pb (.clock, .wr_en, .wr_addr,
      .wr_data(req_table_value), .rd_en(advance), .rd_addr(cx + 1'b1), .rd_data(pb));

   logic [AW-1:0] a0, a1, b0, b1;
   assign a0 = AW'(pa) + cy1_ff;
   assign a1 = a0 + 1'b1;
   assign b0 = AW'(pb) + cy1_ff;
   assign b1 = b0 + 1'b1;

   pn2d_ram #(.WIDTH(VW), .DEPTH(TABLE_SIZE)) u_aa (.clock, .wr_en, .wr_addr,
      .wr_data(req_table_value), .rd_en(advance), .rd_addr(a0), .rd_data(aa));
   pn2d_ram #(.WIDTH(VW), .DEPTH(TABLE_SIZE)) u_ab (.clock, .wr_en, .wr_addr,
      .wr_data(req_table_value), .rd_en(advance), .rd_addr(a1), .rd_data(ab));
   pn2d_ram #(.WIDTH(VW), .DEPTH(TABLE_SIZE)) u_ba (.clock, .wr_en, .wr_addr,
      .wr_data(req_table_value), .rd_en(advance), .rd_addr(b0), .rd_data(ba));
   pn2d_ram #(.WIDTH(VW), .DEPTH(TABLE_SIZE)) u_bb (.clock, .wr_en, .wr_addr,
      .wr_data(req_table_value), .rd_en(advance), .rd_addr(b1), .rd_data(bb));

   always_ff @(posedge clock) begin
      if (advance) begin
         cy1_ff <= cy;
         fx1_ff <= fx_in;
         fy1_ff <= fy_in;
         fx2_ff <= fx1_ff;
         fy2_ff <= fy1_ff;
      end
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= acc && !is_load;
         v2_ff <= v1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_aa = aa[1:0];
   assign out_ab = ab[1:0];
   assign out_ba = ba[1:0];
   assign out_bb = bb[1:0];
   assign out_fx = fx2_ff;
   assign out_fy = fy2_ff;
endmodule

// ===== rtl/pn2d_back.sv =====
// Back part: fade curves, corner gradients, blends and output scaling.
// Uses pn2d_pkg.
module pn2d_back #(
   parameter int FRAC_BITS = pn2d_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [1:0]            in_aa,
   input  logic [1:0]            in_ab,
   input  logic [1:0]            in_ba,
   input  logic [1:0]            in_bb,
   input  logic [FRAC_BITS-1:0]  in_fx,
   input  logic [FRAC_BITS-1:0]  in_fy,
   output logic                  out_valid,
   output logic [pn2d_pkg::NOISE_W-1:0] out_noise
);
   localparam int F  = FRAC_BITS;
   localparam int W  = F + 8;
   localparam int PW = 2 * W;
   localparam int NS = 9;
   localparam logic signed [W-1:0] ONE  = W'(1) <<< F;
   localparam logic signed [PW-1:0] HALF = PW'(1) <<< (F - 1);

   function automatic logic signed [W-1:0] rnd(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] q;
      q = (p + HALF) >>> F;
      return q[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] grad(input logic [1:0] k,
      input logic signed [W-1:0] dx, input logic signed [W-1:0] dy);
      logic signed [W-1:0] u, v;
      u = k[1] ? dy : dx;
      v = k[1] ? dx : dy;
      return (k[0] ? -u : u) + (k[1] ? -v : v);
   endfunction

   function automatic logic signed [W-1:0] clamp1(input logic signed [W-1:0] s);
      if (s < 0) return '0;
      if (s > ONE) return ONE;
      return s;
   endfunction

   function automatic logic [pn2d_pkg::NOISE_W-1:0] scale(input logic signed [W-1:0] v);
      logic [W+16:0] u, q;
      if (v < 0) u = '0;
      else if (v > 2 * ONE) u = (W+17)'(2 * ONE);
      else u = (W+17)'(v);
      if (F > 15) q = (u + ((W+17)'(1) << (F - 16))) >> (F - 15);
      else q = u << (15 - F);
      if (q > (W+17)'(65536)) q = (W+17)'(65536);
      return q[pn2d_pkg::NOISE_W-1:0];
   endfunction

   logic                   v_ff [NS];
   logic signed [W-1:0]    tx_ff [NS], ty_ff [NS];
   logic signed [W-1:0]    sx_ff [NS], sy_ff [NS];
   logic signed [W-1:0]    g0_ff [NS], g1_ff [NS], g2_ff [NS], g3_ff [NS];
   logic signed [W-1:0]    lo_ff, hi_ff, r_ff;
   logic [pn2d_pkg::NOISE_W-1:0] n_ff;

   logic signed [W-1:0] fx, fy, fxm, fym;
   assign fx  = W'({1'b0, in_fx});
   assign fy  = W'({1'b0, in_fy});
   assign fxm = fx - ONE;
   assign fym = fy - ONE;

   always_ff @(posedge clock) begin
      if (advance) begin
         // s0: gradients and 6t-15
         tx_ff[0] <= fx;
         ty_ff[0] <= fy;
         sx_ff[0] <= W'(6 * fx - 15 * ONE);
         sy_ff[0] <= W'(6 * fy - 15 * ONE);
         g0_ff[0] <= grad(in_aa, fx, fy);
         g1_ff[0] <= grad(in_ba, fxm, fy);
         g2_ff[0] <= grad(in_ab, fx, fym);
         g3_ff[0] <= grad(in_bb, fxm, fym);
         for (int i = 1; i < NS; i++) begin
            tx_ff[i] <= tx_ff[i-1];
            ty_ff[i] <= ty_ff[i-1];
            g0_ff[i] <= g0_ff[i-1];
            g1_ff[i] <= g1_ff[i-1];
            g2_ff[i] <= g2_ff[i-1];
            g3_ff[i] <= g3_ff[i-1];
         end
         for (int i = 5; i < NS; i++) begin
            sx_ff[i] <= sx_ff[i-1];
            sy_ff[i] <= sy_ff[i-1];
         end
         // fade: t*s + 10, then three multiplies by t, then clamp
         sx_ff[1] <= W'(rnd(PW'(tx_ff[0]) * PW'(sx_ff[0])) + 10 * ONE);
         sy_ff[1] <= W'(rnd(PW'(ty_ff[0]) * PW'(sy_ff[0])) + 10 * ONE);
         sx_ff[2] <= rnd(PW'(tx_ff[1]) * PW'(sx_ff[1]));
         sy_ff[2] <= rnd(PW'(ty_ff[1]) * PW'(sy_ff[1]));
         sx_ff[3] <= rnd(PW'(tx_ff[2]) * PW'(sx_ff[2]));
         sy_ff[3] <= rnd(PW'(ty_ff[2]) * PW'(sy_ff[2]));
         sx_ff[4] <= clamp1(rnd(PW'(tx_ff[3]) * PW'(sx_ff[3])));
         sy_ff[4] <= clamp1(rnd(PW'(ty_ff[3]) * PW'(sy_ff[3])));
         // blend x
         lo_ff <= g0_ff[4] + rnd(PW'(sx_ff[4]) * PW'(g1_ff[4] - g0_ff[4]));
         hi_ff <= g2_ff[4] + rnd(PW'(sx_ff[4]) * PW'(g3_ff[4] - g2_ff[4]));
         // blend y
         r_ff  <= lo_ff + rnd(PW'(sy_ff[5]) * PW'(hi_ff - lo_ff));
         n_ff  <= scale(r_ff + ONE);
      end
      if (reset) begin
         for (int i = 0; i < NS; i++) v_ff[i] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   // lo/hi land with stage 5, r with 6, n with 7
   assign out_valid = v_ff[7];
   assign out_noise = n_ff;
endmodule

// ===== rtl/perlin_noise_2d_sampler_unit.sv =====
// Top level of the 2D gradient noise sampler: front lookup part, queue, back
// arithmetic part, output queue. Uses pn2d_pkg, pn2d_front, pn2d_fifo, pn2d_back.
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    operation, table_index/value, x/y
//  rsp      out        rsp_valid/stall    noise_value
// One item per cycle while req_stall is low.
// Path: two front lookup stages, the queue, eight back stages, output queue.
// Reset clears only valid state; table contents stay undefined until loaded.
// A stall on rsp fills the output queue, then stalls the back, the queue and req.
module perlin_noise_2d_sampler_unit #(
   parameter int FRAC_BITS  = pn2d_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [pn2d_pkg::IDX_W-1:0]    req_table_index,
   input  logic [pn2d_pkg::VAL_W-1:0]    req_table_value,
   input  logic signed [pn2d_pkg::COORD_W-1:0] req_x_coord,
   input  logic signed [pn2d_pkg::COORD_W-1:0] req_y_coord,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pn2d_pkg::NOISE_W-1:0]  rsp_noise_value
);
   localparam int QW = 8 + 2 * FRAC_BITS;
   logic f_valid, f_adv, q_full, q_empty, b_adv, b_valid;
   logic [1:0] aa, ab, ba, bb, qaa, qab, qba, qbb;
   logic [FRAC_BITS-1:0] fx, fy, qfx, qfy;
   logic [QW-1:0] q_out;
   logic pop, out_pop, ofull, oempty;
   logic [pn2d_pkg::NOISE_W-1:0] rsp_noise_value_pre;

   // advance front while the queue is not full
   assign f_adv = !q_full;

   pn2d_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_operation, .req_table_index,
      .req_table_value, .fx_in(req_x_coord[FRAC_BITS-1:0]),
      .fy_in(req_y_coord[FRAC_BITS-1:0]), .x_in(req_x_coord), .y_in(req_y_coord),
      .advance(f_adv), .out_valid(f_valid), .out_aa(aa), .out_ab(ab),
      .out_ba(ba), .out_bb(bb), .out_fx(fx), .out_fy(fy));

   pn2d_fifo #(.WIDTH(QW), .DEPTH(4)) u_q (
      .clock, .reset, .push(f_valid && f_adv), .push_data({aa, ab, ba, bb, fx, fy}),
      .full(q_full), .pop, .pop_data(q_out), .empty(q_empty));
   assign {qaa, qab, qba, qbb, qfx, qfy} = q_out;

   // advance back while the output queue has room or drains this cycle
   assign b_adv = !ofull || out_pop;
   assign pop   = b_adv && !q_empty;

   pn2d_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .advance(b_adv), .in_valid(!q_empty), .in_aa(qaa),
      .in_ab(qab), .in_ba(qba), .in_bb(qbb), .in_fx(qfx), .in_fy(qfy),
      .out_valid(b_valid), .out_noise(rsp_noise_value_pre));

   assign out_pop = rsp_valid && !rsp_stall;
   pn2d_fifo #(.WIDTH(pn2d_pkg::NOISE_W), .DEPTH(8)) u_oq (
      .clock, .reset, .push(b_valid && b_adv), .push_data(rsp_noise_value_pre),
      .full(ofull), .pop(out_pop), .pop_data(rsp_noise_value), .empty(oempty));
   assign rsp_valid = !oempty;
endmodule

// ===== tb/sv/tb_perlin_noise_2d_sampler_unit.sv =====
// Testbench for perlin_noise_2d_sampler_unit: loads the permutation table, streams
// sample points with random idling on both channels, predicts each noise value.
// Depends on pn2d_pkg and the sampler RTL.
`timescale 1ns / 100ps

module tb_perlin_noise_2d_sampler_unit;
   localparam longint ONE  = 64'sd65536;
   localparam longint HALF = 64'sd32768;
   localparam int LIMIT_CYCLES = 400000;

   typedef struct packed {
      pn2d_pkg::op_type                   op;
      logic [pn2d_pkg::IDX_W-1:0]         idx;
      logic [pn2d_pkg::VAL_W-1:0]         val;
      logic signed [pn2d_pkg::COORD_W-1:0] x;
      logic signed [pn2d_pkg::COORD_W-1:0] y;
   } req_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_operation = 1'b0;
   logic [pn2d_pkg::IDX_W-1:0] req_table_index = '0;
   logic [pn2d_pkg::VAL_W-1:0] req_table_value = '0;
   logic signed [pn2d_pkg::COORD_W-1:0] req_x_coord = '0;
   logic signed [pn2d_pkg::COORD_W-1:0] req_y_coord = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [pn2d_pkg::NOISE_W-1:0] rsp_noise_value;

   req_item_type pending_reqs[$];
   logic [pn2d_pkg::NOISE_W-1:0] expected_noise[$];
   logic [7:0] perm_model[256];
   logic [7:0] perm_shadow[256];

   int unsigned cycle_count = 0;
   int mismatches = 0;
   int samples_sent = 0;
   int loads_sent = 0;
   int noise_seen = 0;
   bit no_idle = 1'b0;

   perlin_noise_2d_sampler_unit u_top (.*);

   always #6 clock = ~clock;

   function automatic longint round_q(input longint p);
      longint q;
      q = p + HALF;
      if (q >= 0) return q >>> 16;
      return -(((-q) + ONE - 1) >>> 16);
   endfunction

   function automatic longint mulq(input longint a, input longint b);
      return round_q(a * b);
   endfunction

   function automatic longint fade_q(input longint t);
      longint s;
      s = mulq(t, 6 * t - 15 * ONE) + 10 * ONE;
      s = mulq(t, mulq(t, mulq(t, s)));
      if (s < 0) s = 0;
      if (s > ONE) s = ONE;
      return s;
   endfunction

   function automatic longint grad_q(input logic [7:0] h, input longint dx, input longint dy);
      longint a, b;
      a = h[1] ? dy : dx;
      b = h[1] ? dx : dy;
      return (h[0] ? -a : a) + (h[1] ? -b : b);
   endfunction

   function automatic logic [pn2d_pkg::NOISE_W-1:0] noise_at(input logic signed [31:0] x,
                                                            input logic signed [31:0] y);
      logic [7:0] cx, cy, pa, pb, aa, ab, ba, bb;
      longint fx, fy, u, w, lo, hi, r, v;
      cx = x[23:16];
      cy = y[23:16];
      fx = longint'(x[15:0]);
      fy = longint'(y[15:0]);
      pa = perm_model[cx];
      pb = perm_model[8'(cx + 8'd1)];
      aa = perm_model[8'(pa + cy)];
      ab = perm_model[8'(pa + cy + 8'd1)];
      ba = perm_model[8'(pb + cy)];
      bb = perm_model[8'(pb + cy + 8'd1)];
      u = fade_q(fx);
      w = fade_q(fy);
      lo = grad_q(aa, fx, fy);
      lo = lo + mulq(u, grad_q(ba, fx - ONE, fy) - lo);
      hi = grad_q(ab, fx, fy - ONE);
      hi = hi + mulq(u, grad_q(bb, fx - ONE, fy - ONE) - hi);
      r = lo + mulq(w, hi - lo);
      v = r + ONE;
      if (v < 0) v = 0;
      if (v > 2 * ONE) v = 2 * ONE;
      v = (v + 1) >>> 1;
      if (v > ONE) v = ONE;
      return pn2d_pkg::NOISE_W'(v);
   endfunction

   task automatic add_load(input int idx, input int val);
      req_item_type it;
      it = '{op: pn2d_pkg::OP_LOAD, idx: idx[7:0], val: val[7:0], x: $urandom, y: $urandom};
      pending_reqs.push_back(it);
      perm_shadow[idx] = val[7:0];
      loads_sent++;
   endtask

   task automatic add_sample(input logic [31:0] x, input logic [31:0] y);
      req_item_type it;
      it = '{op: pn2d_pkg::OP_SAMPLE, idx: 8'($urandom), val: 8'($urandom), x: x, y: y};
      pending_reqs.push_back(it);
      samples_sent++;
   endtask

   // driver
   always @(posedge clock) begin
      req_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            it = pending_reqs.pop_front();
            if (it.op == pn2d_pkg::OP_LOAD) perm_model[it.idx] <= it.val;
            else expected_noise.push_back(noise_at(it.x, it.y));
         end
         if ((!req_valid || !req_stall)) begin
            if (pending_reqs.size() != 0 && (no_idle || $urandom_range(99) >= 37)) begin
               it = pending_reqs[0];
               req_valid <= 1'b1;
               req_operation <= it.op;
               req_table_index <= it.idx;
               req_table_value <= it.val;
               req_x_coord <= it.x;
               req_y_coord <= it.y;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      logic [pn2d_pkg::NOISE_W-1:0] exp_v;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            noise_seen++;
            if (expected_noise.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transfer: noise %0d", rsp_noise_value);
            end else begin
               exp_v = expected_noise.pop_front();
               if (exp_v !== rsp_noise_value) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("noise mismatch: expected %0d actual %0d", exp_v, rsp_noise_value);
               end
            end
         end
         rsp_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 37);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("perlin_noise_2d_sampler_unit verification failed");
         $finish;
      end
   end

   initial begin
      int i, j, t, n, k;
      logic [31:0] xs[8];
      for (i = 0; i < 256; i++) begin
         perm_model[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // identity-shuffled table, full load
      for (i = 0; i < 256; i++) perm_shadow[i] = i[7:0];
      for (i = 255; i > 0; i--) begin
         j = $urandom_range(i);
         t = int'(perm_shadow[i]);
         perm_shadow[i] = perm_shadow[j];
         perm_shadow[j] = t[7:0];
      end
      for (i = 0; i < 256; i++) add_load(i, int'(perm_shadow[i]));

      // directed corners of the coordinate range
      xs = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
             32'h0000_FFFF, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000};
      for (i = 0; i < 8; i++) add_sample(xs[i], xs[(i * 3 + 1) % 8]);
      add_load(0, 255);
      add_load(255, 0);
      add_sample(32'h00FF_8000, 32'h00FF_4000);
      add_sample(32'h0000_4000, 32'hFFFF_C000);
      for (i = 0; i < 4; i++) add_load(i, 255 - i);

      while (pending_reqs.size() != 0 || expected_noise.size() != 0) @(posedge clock);

      n = 0;
      while (n < 1430) begin
         no_idle = (n >= 600 && n < 900);
         k = $urandom_range(99);
         if (k < 8) begin
            add_load($urandom_range(255), $urandom_range(255));
         end else if (k < 70) begin
            add_sample($urandom, $urandom);
         end else if (k < 90) begin
            add_sample({8'($urandom), 8'($urandom_range(3)), 16'($urandom)},
                       {8'($urandom), 8'($urandom_range(3)), 16'($urandom)});
         end else begin
            t = $urandom_range(1);
            add_sample({$urandom_range(1) ? 16'hFFFF : 16'h0, t ? 16'hFFFF : 16'h0},
                       {$urandom_range(1) ? 16'h8000 : 16'h0, 16'($urandom)});
         end
         n++;
         if (pending_reqs.size() > 64) begin
            while (pending_reqs.size() >= 16) @(posedge clock);
         end
      end
      no_idle = 1'b0;
      while (pending_reqs.size() != 0 || expected_noise.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("%0d table loads and %0d sample points sent, %0d noise values checked",
               loads_sent, samples_sent, noise_seen);
      if (mismatches == 0 && expected_noise.size() == 0)
         $display("perlin_noise_2d_sampler_unit verification clean");
      else
         $display("perlin_noise_2d_sampler_unit verification failed");
      $finish;
   end
endmodule
